@@ sv/lira_pkg.sv @@
// shared types and constants of the linear interpolation resampler
package lira_pkg;

  localparam int FIFO_DEPTH_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int STEP_W = 24;
  localparam int FRAC_W = 16;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1558266);

  // half of one output lsb after the fraction is dropped
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_t;

  typedef enum logic {
    ST_OK       = 1'b0,
    ST_UNDERRUN = 1'b1
  } status_t;

endpackage

@@ sv/lira_store.sv @@
// sample pair memory, one write port and two registered read ports
module lira_store #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ sv/lira_lane.sv @@
// one channel of the interpolator: registered multiply, then round and clamp
module lira_lane
  import lira_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] smp_a,
  input  logic signed [SAMPLE_BITS-1:0] smp_b,
  input  logic        [FRAC_W-1:0]      frac,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int DW = SAMPLE_BITS + 1;
  localparam int PW = SAMPLE_BITS + FRAC_W + 2;
  localparam int RW = PW + 1;
  localparam int QW = RW - FRAC_W;

  localparam logic signed [QW-1:0] SMP_MAX = QW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [QW-1:0] SMP_MIN = -SMP_MAX - QW'(1);

  logic signed [DW-1:0]          diff;
  logic signed [FRAC_W:0]        frac_s;
  logic signed [PW-1:0]          prod_next;
  logic signed [PW-1:0]          prod;
  logic signed [SAMPLE_BITS-1:0] base;
  logic signed [RW-1:0]          rnd;
  logic signed [QW-1:0]          step_q;
  logic signed [QW-1:0]          sum;

  // at zero phase only the head sample counts
  always_comb begin
    frac_s    = $signed({1'b0, frac});
    diff      = (frac == '0) ? '0 : (DW'(smp_b) - DW'(smp_a));
    prod_next = PW'(diff) * PW'(frac_s);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
      base <= smp_a;
    end
  end

  // floor of (prod + half) / 2^frac, then clamp as a safeguard
  always_comb begin
    rnd    = RW'(prod) + RW'(ROUND_HALF);
    step_q = QW'(rnd >>> FRAC_W);
    sum    = QW'(base) + step_q;
    if (sum > SMP_MAX) begin
      result = SAMPLE_BITS'(SMP_MAX);
    end else if (sum < SMP_MIN) begin
      result = SAMPLE_BITS'(SMP_MIN);
    end else begin
      result = SAMPLE_BITS'(sum);
    end
  end

endmodule

@@ sv/linear_interp_audio_resampler.sv @@
// top level of the stereo linear interpolation resampler with sample fifo
//
// channel   signals                 contents (lowest bit first)
// ------    ----------------------  ---------------------------------------------
// config    cfg_wr_en, cfg_wr_data  phase_step, unsigned q8.16
// input     s_axis_*                tuser: operation; tdata: sample_left, sample_right
// output    m_axis_*                tuser: pull_status; tdata: frame_left, frame_right
//
// one request is taken per clock while s_axis_tready is high; fifo pointers,
// fill count and phase update in the cycle the request is taken, so requests
// follow back to back; a pull result passes through the registered memory read,
// registered lane multiply, then the output register
// up to three pull results can be held in flight while m_axis_tready is low;
// pushes keep flowing until those stages fill, then s_axis_tready drops
// rst clears pointers, fill count, phase, pipeline valids and restores phase_step;
// the sample memory is not cleared and needs no sweep
module linear_interp_audio_resampler
  import lira_pkg::*;
#(
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [STEP_W-1:0]                      cfg_wr_data,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample_left, sample_right, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // operation
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // frame_left, frame_right, zero pad
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
  // pull_status
  output logic                                   m_axis_tuser
);

  localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W  = $clog2(2 * FIFO_DEPTH);
  localparam int WH_W   = STEP_W - FRAC_W + 1;
  localparam int CMP_W  = (CNT_W > WH_W) ? CNT_W : WH_W;

  // configuration and fifo control state
  logic [STEP_W-1:0] phase_step;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [FRAC_W-1:0] phase, phase_next;

  // pipeline valids and flags
  logic s1_valid, s1_under;
  logic [FRAC_W-1:0] s1_frac;
  logic s2_valid, s2_under;
  logic out_valid;
  logic out_status;
  logic signed [SAMPLE_BITS-1:0] out_left, out_right;

  logic ready_o, ready_s2, ready_s1;
  logic s1_adv, s2_adv;
  logic in_acc, push_acc, pull_acc;

  logic [SUM_W-1:0]  head_inc, tail_inc, head_pop_sum, head_fill_sum;
  logic [PTR_W-1:0]  head_nxt, head_pop, tail_chk;
  logic [STEP_W:0]   phase_sum;
  logic [CMP_W-1:0]  whole_ext, fill_ext;
  logic [CNT_W-1:0]  pop;
  logic              underrun;

  logic [2*SAMPLE_BITS-1:0] rd_pair_a, rd_pair_b;
  logic signed [SAMPLE_BITS-1:0] lane_left, lane_right;

  // ready chain from the output register back to the read stage
  assign ready_o  = !out_valid || m_axis_tready;
  assign ready_s2 = !s2_valid || ready_o;
  assign ready_s1 = !s1_valid || ready_s2;
  assign s1_adv   = s1_valid && ready_s2;
  assign s2_adv   = s2_valid && ready_o;

  assign s_axis_tready = ready_s1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign push_acc      = in_acc && (s_axis_tuser == OP_PUSH);
  assign pull_acc      = in_acc && (s_axis_tuser == OP_PULL);

  // pointer arithmetic, one compare and subtract for the wrap
  always_comb begin
    head_inc = SUM_W'(head) + SUM_W'(1);
    if (head_inc >= SUM_W'(FIFO_DEPTH)) begin
      head_inc = head_inc - SUM_W'(FIFO_DEPTH);
    end
    head_nxt = head_inc[PTR_W-1:0];

    tail_inc = SUM_W'(tail) + SUM_W'(1);
    if (tail_inc >= SUM_W'(FIFO_DEPTH)) begin
      tail_inc = tail_inc - SUM_W'(FIFO_DEPTH);
    end
  end

  // phase advance and pop count, clamped to what the fifo holds
  always_comb begin
    phase_sum = (STEP_W + 1)'(phase) + (STEP_W + 1)'(phase_step);
    whole_ext = CMP_W'(phase_sum[STEP_W:FRAC_W]);
    fill_ext  = CMP_W'(fill);
    pop       = (whole_ext > fill_ext) ? fill : CNT_W'(whole_ext);

    head_pop_sum = SUM_W'(head) + SUM_W'(pop);
    if (head_pop_sum >= SUM_W'(FIFO_DEPTH)) begin
      head_pop_sum = head_pop_sum - SUM_W'(FIFO_DEPTH);
    end
    head_pop = head_pop_sum[PTR_W-1:0];

    // zero phase needs only the head pair
    underrun = (phase == '0) ? (fill == '0) : (fill < CNT_W'(2));
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    fill_next  = fill;
    phase_next = phase;
    if (push_acc) begin
      tail_next = tail_inc[PTR_W-1:0];
      // full fifo drops the oldest pair
      if (fill == CNT_W'(FIFO_DEPTH)) begin
        head_next = head_nxt;
      end else begin
        fill_next = fill + CNT_W'(1);
      end
    end
    if (pull_acc && !underrun) begin
      head_next  = head_pop;
      fill_next  = fill - pop;
      phase_next = phase_sum[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
      phase      <= '0;
    end else begin
      if (cfg_wr_en) begin
        phase_step <= cfg_wr_data;
      end
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
      phase <= phase_next;
    end
  end

  // sample pairs stored as {right, left}; head and the pair after it are read
  lira_store #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (2 * SAMPLE_BITS)
  ) u_store (
    .clk       (clk),
    .wr_en     (push_acc),
    .wr_addr   (tail),
    .wr_data   (s_axis_tdata[2*SAMPLE_BITS-1:0]),
    .rd_en     (pull_acc),
    .rd_addr_a (head),
    .rd_addr_b (head_nxt),
    .rd_data_a (rd_pair_a),
    .rd_data_b (rd_pair_b)
  );

  // read stage flags, aligned with the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pull_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pull_acc) begin
      s1_under <= underrun;
      s1_frac  <= phase;
    end
  end

  // one lane per channel, both loaded when the read stage moves on
  lira_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk    (clk),
    .load   (s1_adv),
    .smp_a  (rd_pair_a[SAMPLE_BITS-1:0]),
    .smp_b  (rd_pair_b[SAMPLE_BITS-1:0]),
    .frac   (s1_frac),
    .result (lane_left)
  );

  lira_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk    (clk),
    .load   (s1_adv),
    .smp_a  (rd_pair_a[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .smp_b  (rd_pair_b[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .frac   (s1_frac),
    .result (lane_right)
  );

  // multiply stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_under <= s1_under;
    end
  end

  // merge stage: both lanes into one frame, underrun forces zero samples
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_status <= s2_under ? ST_UNDERRUN : ST_OK;
      out_left   <= s2_under ? '0 : lane_left;
      out_right  <= s2_under ? '0 : lane_right;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = DATA_W'({out_right, out_left});

  // where the tail should sit given head and fill count
  always_comb begin
    head_fill_sum = SUM_W'(head) + SUM_W'(fill);
    if (head_fill_sum >= SUM_W'(FIFO_DEPTH)) begin
      head_fill_sum = head_fill_sum - SUM_W'(FIFO_DEPTH);
    end
    tail_chk = head_fill_sum[PTR_W-1:0];
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(FIFO_DEPTH))
    else $error("fill count beyond fifo depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    tail == tail_chk)
    else $error("tail pointer out of step with head and fill count");

  a_underrun_no_change: assert property (@(posedge clk) disable iff (rst)
    pull_acc && underrun |=> $stable(fill) && $stable(head) && $stable(phase))
    else $error("underrun pull changed fifo state");

  a_overflow_stays_full: assert property (@(posedge clk) disable iff (rst)
    push_acc && (fill == CNT_W'(FIFO_DEPTH)) |=> fill == CNT_W'(FIFO_DEPTH))
    else $error("push into full fifo changed fill count");

  a_underrun_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_UNDERRUN) |-> (out_left == '0) && (out_right == '0))
    else $error("underrun result carries nonzero samples");

endmodule
